FILE: rtl/ecdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Empirical CDF sampler package
// Sizes, operation and status codes, and the command and flag words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ecdf_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int UN_W        = FRAC_W + CNT_W;
    localparam int T_W         = FRAC_W + 1;
    localparam int DIFF_W      = VAL_W + 1;
    localparam int PROD_W      = T_W + 1 + DIFF_W;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_CLEAR = 2'd0;
    localparam opcode_t OP_LOAD  = 2'd1;
    localparam opcode_t OP_DRAW  = 2'd2;
    localparam opcode_t OP_NONE  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_DRAW_OK = 2'd0;
    localparam status_t ST_DONE    = 2'd1;
    localparam status_t ST_FULL    = 2'd2;
    localparam status_t ST_TOO_FEW = 2'd3;

    typedef struct packed {
        logic    latch;
        logic    clear_count;
        logic    inc_count;
        logic    ld_init;
        logic    ld_shift;
        logic    ld_put;
        logic    dr_mul;
        logic    dr_idx;
        logic    dr_lo;
        logic    dr_hi;
        logic    dr_prod;
        logic    dr_sum;
        logic    emit;
        status_t emit_status;
    } ecdf_cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    full;
        logic    few;
        logic    idx_zero;
        logic    gt;
        logic    out_free;
    } ecdf_flags_t;

endpackage
`default_nettype wire

FILE: rtl/ecdf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Empirical CDF sampler request channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface ecdf_req_if
    import ecdf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    opcode_t                 opcode;
    logic signed [VAL_W-1:0] sample_value;
    logic [FRAC_W-1:0]       uniform_fraction;

    modport source (
        output valid,
        output opcode,
        output sample_value,
        output uniform_fraction,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  sample_value,
        input  uniform_fraction,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/ecdf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Empirical CDF sampler response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface ecdf_rsp_if
    import ecdf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] drawn_value;
    status_t                 status;

    modport source (
        output valid,
        output drawn_value,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  drawn_value,
        input  status,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/empirical_cdf_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Empirical CDF sampler
// Sorted sample table with inverse-transform draws by linear interpolation.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and returns one result word for
// each clear, load or draw; an unused opcode is consumed without a result.
// A clear, a load into a full table and a draw with fewer than two samples
// go straight from dispatch to the finishing state. A load shifts every
// stored sample that is greater than the new one up by one entry, testing
// and comparing from the top of the table down, to keep the table sorted,
// and then writes the new sample into the gap. A draw scales the fraction
// by the sample count, reads the table twice for the neighboring samples,
// and follows with the multiply and the final add. A finished result sits
// in an output register, and the next request is accepted once the
// controller is back in idle, even while that result waits to be taken;
// the following result then waits until the output register is free.
// ----------------------------------------------------------------------------
module empirical_cdf_sampler_unit
    import ecdf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ecdf_req_if.sink  req,
    ecdf_rsp_if.source rsp
);
    ecdf_cmd_t   cmd;
    ecdf_flags_t flags;

    ecdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    ecdf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .flags            (flags),
        .opcode           (req.opcode),
        .sample_value     (req.sample_value),
        .uniform_fraction (req.uniform_fraction),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .drawn_value      (rsp.drawn_value),
        .status           (rsp.status)
    );
endmodule
`default_nettype wire

FILE: rtl/ecdf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ecdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/ecdf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Empirical CDF sampler controller
// Sequences clear, sorted insertion and interpolated draw over the datapath.
// ----------------------------------------------------------------------------
module ecdf_ctrl
    import ecdf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire ecdf_flags_t flags,
    output ecdf_cmd_t        cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_LD_TEST  = 4'd2;
    localparam logic [3:0] S_LD_CMP   = 4'd3;
    localparam logic [3:0] S_DR_IDX   = 4'd4;
    localparam logic [3:0] S_DR_LO    = 4'd5;
    localparam logic [3:0] S_DR_HI    = 4'd6;
    localparam logic [3:0] S_DR_PROD  = 4'd7;
    localparam logic [3:0] S_DR_SUM   = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    status_t    code_reg;
    status_t    code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = req_valid;
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (flags.opcode)
                    OP_CLEAR:
                    begin
                        cmd.clear_count = 1'b1;
                        code_next       = ST_DONE;
                        state_next      = S_FINISH;
                    end
                    OP_LOAD:
                    begin
                        if (flags.full)
                        begin
                            code_next  = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.ld_init = 1'b1;
                            state_next  = S_LD_TEST;
                        end
                    end
                    OP_DRAW:
                    begin
                        if (flags.few)
                        begin
                            code_next  = ST_TOO_FEW;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.dr_mul = 1'b1;
                            state_next = S_DR_IDX;
                        end
                    end
                    OP_NONE:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LD_TEST:
            begin
                if (flags.idx_zero)
                begin
                    cmd.ld_put    = 1'b1;
                    cmd.inc_count = 1'b1;
                    code_next     = ST_DONE;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_LD_CMP;
                end
            end
            S_LD_CMP:
            begin
                if (flags.gt)
                begin
                    cmd.ld_shift = 1'b1;
                    state_next   = S_LD_TEST;
                end
                else
                begin
                    cmd.ld_put    = 1'b1;
                    cmd.inc_count = 1'b1;
                    code_next     = ST_DONE;
                    state_next    = S_FINISH;
                end
            end
            S_DR_IDX:
            begin
                cmd.dr_idx = 1'b1;
                state_next = S_DR_LO;
            end
            S_DR_LO:
            begin
                cmd.dr_lo  = 1'b1;
                state_next = S_DR_HI;
            end
            S_DR_HI:
            begin
                cmd.dr_hi  = 1'b1;
                state_next = S_DR_PROD;
            end
            S_DR_PROD:
            begin
                cmd.dr_prod = 1'b1;
                state_next  = S_DR_SUM;
            end
            S_DR_SUM:
            begin
                cmd.dr_sum = 1'b1;
                code_next  = ST_DRAW_OK;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.emit_status = code_reg;
                if (flags.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/ecdf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Empirical CDF sampler datapath
// Sample table, count, interpolation arithmetic and the result register.
// ----------------------------------------------------------------------------
module ecdf_dp
    import ecdf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ecdf_cmd_t               cmd,
    output ecdf_flags_t                  flags,
    input  wire opcode_t                 opcode,
    input  wire logic signed [VAL_W-1:0] sample_value,
    input  wire logic [FRAC_W-1:0]       uniform_fraction,
    output logic                         rsp_valid,
    input  wire logic                    rsp_ready,
    output logic signed [VAL_W-1:0]      drawn_value,
    output status_t                      status
);
    opcode_t                  opcode_reg;
    logic signed [VAL_W-1:0]  value_reg;
    logic [FRAC_W-1:0]        frac_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [UN_W-1:0]          un_reg;
    logic [T_W-1:0]           t_reg;
    logic signed [VAL_W-1:0]  lo_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  sum_reg;
    logic                     rsp_valid_reg;
    logic signed [VAL_W-1:0]  drawn_reg;
    status_t                  status_reg;

    logic [VAL_W-1:0]         rd_data;
    logic signed [VAL_W-1:0]  rd_sample;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [VAL_W-1:0]         ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [CNT_W-1:0]         raddr_full;

    logic [UN_W:0]            un_up;
    logic [CNT_W:0]           ceil_v;
    logic [CNT_W:0]           seg_w;
    logic [CNT_W-1:0]         seg;
    logic [CNT_W-1:0]         lo_idx;
    logic [UN_W-1:0]          t_full;
    logic signed [T_W:0]      t_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] round_add;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [PROD_W-1:0] quot;

    assign rd_sample = $signed(rd_data);

    // The segment index is ceil(u*n)-1, floored at zero; t is the step inside it.
    assign un_up  = {1'b0, un_reg} + (UN_W + 1)'((2 ** FRAC_W) - 1);
    assign ceil_v = un_up[UN_W:FRAC_W];
    assign seg_w  = (ceil_v == '0) ? '0 : ceil_v - (CNT_W + 1)'(1);
    assign seg    = seg_w[CNT_W-1:0];
    assign lo_idx = (seg == '0) ? '0 : seg - CNT_W'(1);
    assign t_full = un_reg - {seg, {FRAC_W{1'b0}}};

    assign t_s       = {1'b0, t_reg};
    assign prod_next = t_s * diff_reg;
    assign round_add = prod_reg[PROD_W-1] ? PROD_W'((2 ** FRAC_W) - 1) : '0;
    assign prod_adj  = prod_reg + round_add;
    assign quot      = prod_adj >>> FRAC_W;

    always_comb
    begin
        priority if (cmd.dr_idx)
        begin
            raddr_full = lo_idx;
        end
        else if (cmd.dr_lo)
        begin
            raddr_full = idx_reg + CNT_W'(1);
        end
        else
        begin
            raddr_full = idx_reg - CNT_W'(1);
        end
    end

    assign ram_raddr = raddr_full[ADDR_W-1:0];
    assign ram_we    = cmd.ld_shift | cmd.ld_put;
    assign ram_waddr = idx_reg[ADDR_W-1:0];
    assign ram_wdata = cmd.ld_shift ? rd_data : value_reg;

    ecdf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_SAMPLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            opcode_reg <= opcode;
            value_reg  <= sample_value;
            frac_reg   <= uniform_fraction;
        end
        if (cmd.ld_init)
        begin
            idx_reg <= count_reg;
        end
        else if (cmd.ld_shift)
        begin
            idx_reg <= idx_reg - CNT_W'(1);
        end
        else if (cmd.dr_idx)
        begin
            idx_reg <= lo_idx;
        end
        if (cmd.dr_mul)
        begin
            un_reg <= UN_W'(frac_reg) * UN_W'(count_reg);
        end
        if (cmd.dr_idx)
        begin
            t_reg <= t_full[T_W-1:0];
        end
        if (cmd.dr_lo)
        begin
            lo_reg <= rd_sample;
        end
        if (cmd.dr_hi)
        begin
            diff_reg <= DIFF_W'(rd_sample) - DIFF_W'(lo_reg);
        end
        if (cmd.dr_prod)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.dr_sum)
        begin
            sum_reg <= lo_reg + $signed(quot[VAL_W-1:0]);
        end
        if (cmd.emit)
        begin
            drawn_reg  <= (cmd.emit_status == ST_DRAW_OK) ? sum_reg : '0;
            status_reg <= cmd.emit_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.inc_count)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign flags.opcode   = opcode_reg;
    assign flags.full     = (count_reg == CNT_W'(MAX_SAMPLES));
    assign flags.few      = (count_reg < CNT_W'(2));
    assign flags.idx_zero = (idx_reg == '0);
    assign flags.gt       = (rd_sample > value_reg);
    assign flags.out_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid   = rsp_valid_reg;
    assign drawn_value = drawn_reg;
    assign status      = status_reg;
endmodule
`default_nettype wire

FILE: rtl/ecdf_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Empirical CDF sampler checker
// Port-level properties of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module ecdf_chk
    import ecdf_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    req_valid,
    input wire logic                    req_ready,
    input wire opcode_t                 req_opcode,
    input wire logic                    rsp_valid,
    input wire logic                    rsp_ready,
    input wire logic signed [VAL_W-1:0] rsp_drawn_value,
    input wire status_t                 rsp_status
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drawn_value)
            && $stable(rsp_status))
        else $error("Stalled result word changed.");

    a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_DRAW_OK |-> rsp_drawn_value == '0)
        else $error("Nonzero value in a result word that is not a draw.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request word accepted while another is in progress.");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_opcode == OP_CLEAR && !rsp_valid
            |-> ##3 (rsp_valid && rsp_status == ST_DONE))
        else $error("Clear did not complete in three cycles.");
endmodule

bind empirical_cdf_sampler_unit ecdf_chk u_ecdf_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_opcode      (req.opcode),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_drawn_value (rsp.drawn_value),
    .rsp_status      (rsp.status)
);
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Empirical CDF sampler testbench
// Drives clear, load, draw and unused request words into the sampler with
// random gaps on both channels, mirrors the sorted table and the interpolated
// draw in a local predictor, and compares every result word in order.
// ----------------------------------------------------------------------------
module testbench;
    import ecdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 1000;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        status_t                 status;
    } ecdf_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ecdf_req_if req_ch ();
    ecdf_rsp_if rsp_ch ();

    empirical_cdf_sampler_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    logic signed [VAL_W-1:0] ecdf_table [MAX_SAMPLES];
    int                      table_count = 0;
    ecdf_result_t            expected_results [$];
    int                      failures    = 0;
    int                      items_done  = 0;
    int                      idle_cycles = 0;
    bit                      no_gaps     = 1'b0;

    always #5 clk = ~clk;

    function automatic int pick_gap();
        if (no_gaps)
        begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic signed [VAL_W-1:0] interpolate_draw(logic [FRAC_W-1:0] frac);
        longint scaled;
        longint ceil_idx;
        longint idx;
        longint lo;
        longint hi;
        longint offset;
        longint sum;
        scaled   = longint'(frac) * table_count;
        ceil_idx = (scaled + 64'sh0000_FFFF) >>> 16;
        idx      = (ceil_idx > 0) ? ceil_idx - 1 : 0;
        if (idx == 0)
        begin
            lo     = ecdf_table[0];
            hi     = ecdf_table[1];
            offset = scaled;
        end
        else
        begin
            if (idx > table_count - 1)
            begin
                idx = table_count - 1;
            end
            lo     = ecdf_table[idx - 1];
            hi     = ecdf_table[idx];
            offset = scaled - (idx <<< 16);
        end
        sum = lo + (offset * (hi - lo)) / 64'sd65536;
        return sum[VAL_W-1:0];
    endfunction

    task automatic apply_word(input opcode_t op, input logic signed [VAL_W-1:0] value,
                              input logic [FRAC_W-1:0] frac);
        ecdf_result_t res;
        int           pos;
        res.value  = '0;
        res.status = ST_DONE;
        case (op)
            OP_CLEAR:
            begin
                table_count = 0;
            end
            OP_LOAD:
            begin
                if (table_count >= MAX_SAMPLES)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < table_count && ecdf_table[pos] <= value)
                    begin
                        pos++;
                    end
                    for (int k = table_count; k > pos; k--)
                    begin
                        ecdf_table[k] = ecdf_table[k - 1];
                    end
                    ecdf_table[pos] = value;
                    table_count++;
                end
            end
            OP_DRAW:
            begin
                if (table_count < 2)
                begin
                    res.status = ST_TOO_FEW;
                end
                else
                begin
                    res.status = ST_DRAW_OK;
                    res.value  = interpolate_draw(frac);
                end
            end
            default:
            begin
                return;
            end
        endcase
        items_done++;
        expected_results.push_back(res);
    endtask

    task automatic send_word(input opcode_t op, input logic signed [VAL_W-1:0] value,
                             input logic [FRAC_W-1:0] frac);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.opcode           <= op;
        req_ch.sample_value     <= value;
        req_ch.uniform_fraction <= frac;
        do @(posedge clk); while (!req_ch.ready);
        apply_word(op, value, frac);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value(int style);
        case (style)
            0: return $urandom;
            1: return 32'($urandom_range(0, 262143)) - 32'd131072;
            2: return 32'($urandom_range(0, 3)) << 16;
            default:
            begin
                case ($urandom_range(0, 2))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            return 16'h0000;
        end
        if (sel == 1)
        begin
            return 16'hFFFF;
        end
        if (sel < 6 && table_count >= 2)
        begin
            return 16'((longint'($urandom_range(1, table_count - 1)) << 16) / table_count);
        end
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        send_word(OP_CLEAR, 32'sh0, 16'h0);
        send_word(OP_DRAW, 32'sh0, 16'h1234);
        send_word(OP_LOAD, 32'sh0005_0000, 16'h0);
        send_word(OP_DRAW, 32'sh0, 16'h1234);
        send_word(OP_NONE, 32'h7FFF_FFFF, 16'hFFFF);
        send_word(OP_LOAD, 32'h7FFF_FFFF, 16'h0);
        send_word(OP_LOAD, 32'h8000_0000, 16'h0);
        send_word(OP_DRAW, 32'sh0, 16'h0000);
        send_word(OP_DRAW, 32'sh0, 16'hFFFF);
        send_word(OP_LOAD, 32'sh0005_0000, 16'h0);
        send_word(OP_DRAW, 32'sh0, 16'h4000);
        send_word(OP_DRAW, 32'sh0, 16'h8000);
        send_word(OP_DRAW, 32'sh0, 16'hC000);
        send_word(OP_DRAW, 32'sh0, 16'h0001);
        send_word(OP_DRAW, 32'sh0, 16'h2000);
        send_word(OP_CLEAR, 32'sh0, 16'h0);
        send_word(OP_DRAW, 32'sh0, 16'h8000);
        send_word(OP_LOAD, 32'shFFFE_8000, 16'h0);
        send_word(OP_LOAD, 32'shFFFE_8000, 16'h0);
        send_word(OP_DRAW, 32'sh0, 16'h8000);
        send_word(OP_DRAW, 32'sh0, 16'($urandom));
        send_word(OP_NONE, 32'sh0, 16'h0);
        send_word(OP_CLEAR, 32'sh0, 16'h0);
    endtask

    task automatic test_full_table();
        send_word(OP_CLEAR, 32'sh0, 16'h0);
        for (int k = 0; k < MAX_SAMPLES; k++)
        begin
            send_word(OP_LOAD, pick_value($urandom_range(0, 3)), 16'($urandom));
        end
        send_word(OP_LOAD, 32'sh0001_0000, 16'h0);
        send_word(OP_LOAD, pick_value(0), 16'h0);
        send_word(OP_DRAW, 32'sh0, 16'h0000);
        send_word(OP_DRAW, 32'sh0, 16'hFFFF);
        send_word(OP_DRAW, 32'sh0, 16'h0400);
        send_word(OP_DRAW, 32'sh0, 16'hFC00);
        for (int k = 0; k < 4; k++)
        begin
            send_word(OP_DRAW, 32'sh0, pick_fraction());
        end
        send_word(OP_CLEAR, 32'sh0, 16'h0);
    endtask

    task automatic test_random();
        int target;
        int n_loads;
        int n_draws;
        int style;
        int sel;
        target = items_done + RANDOM_ITEMS;
        while (items_done < target)
        begin
            no_gaps = ($urandom_range(0, 7) == 0);
            style   = $urandom_range(0, 3);
            if ($urandom_range(0, 4) != 0)
            begin
                send_word(OP_CLEAR, $urandom, 16'($urandom));
            end
            sel = $urandom_range(0, 19);
            if (sel < 16)
            begin
                n_loads = $urandom_range(0, 8);
            end
            else if (sel < 19)
            begin
                n_loads = $urandom_range(9, 40);
            end
            else
            begin
                n_loads = $urandom_range(41, 70);
            end
            for (int k = 0; k < n_loads; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_word(opcode_t'($urandom_range(0, 3)), $urandom, 16'($urandom));
                end
                send_word(OP_LOAD, pick_value(style), 16'($urandom));
            end
            n_draws = $urandom_range(1, 12);
            for (int k = 0; k < n_draws; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_word(opcode_t'($urandom_range(0, 3)), $urandom, 16'($urandom));
                end
                send_word(OP_DRAW, $urandom, pick_fraction());
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.opcode           <= OP_CLEAR;
        req_ch.sample_value     <= '0;
        req_ch.uniform_fraction <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        ecdf_result_t exp_word;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word: drawn_value %0d, status %0d",
                       rsp_ch.drawn_value, rsp_ch.status);
                failures++;
            end
            else
            begin
                exp_word = expected_results.pop_front();
                if (rsp_ch.drawn_value !== exp_word.value)
                begin
                    $error("drawn_value: expected %0d, actual %0d",
                           exp_word.value, rsp_ch.drawn_value);
                    failures++;
                end
                if (rsp_ch.status !== exp_word.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           exp_word.status, rsp_ch.status);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end
endmodule

FILE: empirical_cdf_sampler_unit.f
rtl/ecdf_pkg.sv
rtl/ecdf_req_if.sv
rtl/ecdf_rsp_if.sv
rtl/ecdf_ram.sv
rtl/ecdf_ctrl.sv
rtl/ecdf_dp.sv
rtl/empirical_cdf_sampler_unit.sv
rtl/ecdf_chk.sv
tb/testbench.sv
